// File: hw/rtl/gics_pkg.sv
// Shared constants, types and the CDF table builder of the gaussian inverse-CDF sampler.
`default_nettype none
package gics_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TBL_AW = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int SMP_W = 15;
    localparam int OUT_W = 15;
    localparam int CDF_W = 16;
    localparam int SCL_W = SMP_W + CDF_W;
    localparam int DEN_W = SCL_W;
    localparam int PROD_W = DEN_W + CNT_W;
    localparam int QUO_W = OUT_W;
    localparam int DVD_W = PROD_W + QUO_W;

    localparam int IN_TDATA_W = ((SMP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic signed [OUT_W:0] OUT_PLUS3 = (OUT_W + 1)'(12288);
    localparam logic signed [OUT_W:0] OUT_MINUS3 = -(OUT_W + 1)'(12288);

    localparam logic [63:0] TBL_LEN = 64'(TABLE_ENTRIES);
    localparam logic [63:0] TBL_LEN_SQ = TBL_LEN * TBL_LEN;
    localparam logic [63:0] CDF_DIVISOR = TBL_LEN * 64'd16384;
    localparam logic [63:0] CDF_HALF = TBL_LEN * 64'd8192;

    // ceil(2^RECIP_SHIFT / k) for the Taylor term index k
    localparam int RECIP_SHIFT = 38;
    localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
    localparam logic [63:0] TERM_RECIP [17] = '{
        64'd0,
        RECIP_ONE,
        (RECIP_ONE + 64'd1) / 64'd2,
        (RECIP_ONE + 64'd2) / 64'd3,
        (RECIP_ONE + 64'd3) / 64'd4,
        (RECIP_ONE + 64'd4) / 64'd5,
        (RECIP_ONE + 64'd5) / 64'd6,
        (RECIP_ONE + 64'd6) / 64'd7,
        (RECIP_ONE + 64'd7) / 64'd8,
        (RECIP_ONE + 64'd8) / 64'd9,
        (RECIP_ONE + 64'd9) / 64'd10,
        (RECIP_ONE + 64'd10) / 64'd11,
        (RECIP_ONE + 64'd11) / 64'd12,
        (RECIP_ONE + 64'd12) / 64'd13,
        (RECIP_ONE + 64'd13) / 64'd14,
        (RECIP_ONE + 64'd14) / 64'd15,
        (RECIP_ONE + 64'd15) / 64'd16
    };

    typedef logic [CDF_W-1:0] cdf_tbl_t [TABLE_ENTRIES];

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [PROD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [63:0] exp_neg_int(input logic [63:0] n);
        logic [63:0] v;
        unique case (n)
            64'd0:   v = 64'd1073741824;
            64'd1:   v = 64'd395007542;
            64'd2:   v = 64'd145315154;
            64'd3:   v = 64'd53458458;
            default: v = 64'd19666267;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
        logic [63:0]  n;
        logic [63:0]  f;
        logic [63:0]  term;
        logic [127:0] prod;
        longint       res;
        n = t >> 30;
        f = t & 64'd1073741823;
        res = 64'sd1073741824;
        term = 64'd1073741824;
        if (n > 64'd4)
        begin
            return 64'd0;
        end
        for (int k = 1; k <= 16; k++)
        begin
            prod = 128'((term * f) >> 30) * 128'(TERM_RECIP[k]);
            term = 64'(prod >> RECIP_SHIFT);
            if (k[0])
            begin
                res = res - longint'(term);
            end
            else
            begin
                res = res + longint'(term);
            end
        end
        if (res < 0)
        begin
            res = 0;
        end
        return (64'(res) * exp_neg_int(n)) >> 30;
    endfunction

    function automatic logic [63:0] density_q30(input logic [63:0] j);
        logic [63:0] len;
        logic [63:0] d;
        logic [63:0] t;
        len = TBL_LEN;
        d = (j >= len) ? (j - len) : (len - j);
        t = ((64'd9 * d * d) << 29) / TBL_LEN_SQ;
        return (64'd428361011 * exp_neg_q30(t)) >> 30;
    endfunction

    function automatic cdf_tbl_t build_cdf_table();
        cdf_tbl_t    tbl;
        logic [63:0] acc;
        logic [63:0] v;
        logic [63:0] ii;
        acc = 64'd0;
        tbl[0] = '0;
        for (int i = 1; i < TABLE_ENTRIES; i++)
        begin
            ii = 64'(i);
            acc = acc + density_q30(2 * ii - 2) + 64'd4 * density_q30(2 * ii - 1)
                + density_q30(2 * ii);
            v = (acc + CDF_HALF) / CDF_DIVISOR;
            if (v > 64'd65535)
            begin
                v = 64'd65535;
            end
            tbl[i] = v[CDF_W-1:0];
        end
        return tbl;
    endfunction

    localparam cdf_tbl_t CDF_TABLE = build_cdf_table();

endpackage
`default_nettype wire

// File: hw/rtl/gics_cdf_rom.sv
// Synchronous-read CDF table memory, one read port, registered read data.
`default_nettype none
module gics_cdf_rom
    import gics_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [TBL_AW-1:0] addr,
    output logic [CDF_W-1:0]       rd_data
);

    logic [CDF_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= CDF_TABLE[addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hw/rtl/gics_divider.sv
// Radix-2 restoring divider producing the interpolated grid position.
`default_nettype none
module gics_divider
    import gics_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_req_t req,
    output div_rsp_t  rsp
);

    logic [DVD_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [QUO_W-1:0] mask_reg, mask_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quo_next = quo_reg;
        mask_next = mask_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = req.dividend;
            dsh_next = DVD_W'(req.divisor) << (QUO_W - 1);
            quo_next = '0;
            mask_next = QUO_W'(1) << (QUO_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                quo_next = quo_reg | mask_reg;
            end
            dsh_next = dsh_reg >> 1;
            mask_next = mask_reg >> 1;
            if (mask_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mask_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

// File: hw/rtl/gaussian_inverse_cdf_sampler.sv
// A zero sample goes straight to the output; any other runs the binary search, which ends a
// saturating sample at the top value, and the rest go on through the interpolation steps and the divider.
// One sample at a time, taken only in idle; the pace is set by the binary search over the single
// CDF table read port and the 15-step radix-2 divider; a stalled result holds the sequencer.
// Reset clears the sequencer, the divider control and the output valid; the table is constant.
`default_nettype none
module gaussian_inverse_cdf_sampler
    import gics_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [14:0] uniform_sample
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // [14:0] normal_value
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_PROBE  = 9'b000000010,
        ST_CMP    = 9'b000000100,
        ST_RD_HI  = 9'b000001000,
        ST_CALC1  = 9'b000010000,
        ST_CALC2  = 9'b000100000,
        ST_CALC3  = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [SCL_W-1:0]       scaled_reg, scaled_next;
    logic [TBL_AW-1:0]      pos_reg, pos_next;
    logic [TBL_AW-1:0]      mask_reg, mask_next;
    logic [CDF_W-1:0]       lo_reg, lo_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [SCL_W-1:0]       resid_reg, resid_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [PROD_W-1:0]      dvs_reg, dvs_next;
    logic signed [OUT_W-1:0] result_reg, result_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    logic [TBL_AW-1:0] rom_addr;
    logic [CDF_W-1:0]  rom_data;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [SMP_W-1:0]     sample;
    logic [TBL_AW-1:0]    cand;
    logic                 cand_ok;
    logic [SCL_W-1:0]     rd_scaled;
    logic [SCL_W-1:0]     lo_scaled;
    logic [CDF_W-1:0]     span;
    logic [DEN_W-1:0]     den_calc;
    logic                 pos_last;
    logic [PROD_W-1:0]    mul_w;
    logic signed [OUT_W:0] res_w;

    gics_cdf_rom u_rom (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (rom_data)
    );

    gics_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sample = s_axis_tdata[SMP_W-1:0];
    assign cand = pos_reg | mask_reg;
    assign cand_ok = CNT_W'(cand) < CNT_W'(TABLE_ENTRIES);
    assign rd_scaled = {rom_data, {SMP_W{1'b0}}} - SCL_W'(rom_data);
    assign lo_scaled = {lo_reg, {SMP_W{1'b0}}} - SCL_W'(lo_reg);
    assign span = rom_data - lo_reg;
    assign den_calc = {span, {SMP_W{1'b0}}} - DEN_W'(span);
    assign pos_last = pos_reg == TBL_AW'(TABLE_ENTRIES - 1);
    assign mul_w = PROD_W'(pos_reg) * PROD_W'(den_reg);
    assign res_w = $signed({1'b0, div_rsp.quotient}) - OUT_PLUS3;

    always_comb
    begin
        state_next = state_reg;
        scaled_next = scaled_reg;
        pos_next = pos_reg;
        mask_next = mask_reg;
        lo_next = lo_reg;
        den_next = den_reg;
        resid_next = resid_reg;
        prod_next = prod_reg;
        dvs_next = dvs_reg;
        result_next = result_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        rom_addr = cand;
        div_req.start = 1'b0;
        div_req.dividend = DVD_W'({prod_reg, 14'b0}) + DVD_W'({prod_reg, 13'b0})
            + DVD_W'(dvs_reg >> 1);
        div_req.divisor = dvs_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    scaled_next = {sample, {CDF_W{1'b0}}};
                    pos_next = '0;
                    mask_next = TBL_AW'(1) << (TBL_AW - 1);
                    if (sample == '0)
                    begin
                        result_next = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (mask_reg == '0)
                begin
                    rom_addr = pos_reg;
                    if (pos_last)
                    begin
                        result_next = OUT_PLUS3[OUT_W-1:0];
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_RD_HI;
                    end
                end
                else if (cand_ok)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    mask_next = mask_reg >> 1;
                end
            end
            ST_CMP:
            begin
                if (rd_scaled < scaled_reg)
                begin
                    pos_next = cand;
                end
                mask_next = mask_reg >> 1;
                state_next = ST_PROBE;
            end
            ST_RD_HI:
            begin
                rom_addr = pos_reg + 1'b1;
                lo_next = rom_data;
                state_next = ST_CALC1;
            end
            ST_CALC1:
            begin
                den_next = den_calc;
                resid_next = scaled_reg - lo_scaled;
                state_next = ST_CALC2;
            end
            ST_CALC2:
            begin
                if (den_reg == '0)
                begin
                    prod_next = PROD_W'(pos_reg);
                    dvs_next = PROD_W'(TABLE_ENTRIES);
                end
                else
                begin
                    prod_next = mul_w + PROD_W'(resid_reg);
                    dvs_next = PROD_W'(den_reg) * PROD_W'(TABLE_ENTRIES);
                end
                state_next = ST_CALC3;
            end
            ST_CALC3:
            begin
                div_req.start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    priority if (res_w > OUT_PLUS3)
                    begin
                        result_next = OUT_PLUS3[OUT_W-1:0];
                    end
                    else if (res_w < OUT_MINUS3)
                    begin
                        result_next = OUT_MINUS3[OUT_W-1:0];
                    end
                    else
                    begin
                        result_next = res_w[OUT_W-1:0];
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = result_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mask_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
        pos_reg <= pos_next;
        lo_reg <= lo_next;
        den_reg <= den_next;
        resid_reg <= resid_next;
        prod_reg <= prod_next;
        dvs_reg <= dvs_next;
        result_reg <= result_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = OUT_TDATA_W'(out_data_reg);

`ifndef SYNTH
    a_div_done_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_rsp.done) |=> (state_reg == ST_FINISH))
        else $error("divider result not taken");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(out_data_reg) <= OUT_PLUS3 &&
                           $signed(out_data_reg) >= OUT_MINUS3))
        else $error("output outside plus or minus three");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_rsp.busy)
        else $error("divider busy while sequencer idle");
`endif

endmodule
`default_nettype wire

// File: tb/normal_sample_checker.sv
`timescale 1ns / 100ps
// Watches both channels of the gaussian sampler, predicts each normal value and compares.
module normal_sample_checker
    import gics_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [14:0] uniform_sample
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [14:0] normal_value
    output int                     errors,
    output int                     pending,
    output int                     checked,
    output int                     zero_cnt,
    output int                     top_cnt
);

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] Q30_FRAC = 64'd1073741823;
    localparam logic [63:0] PDF_SCALE = 64'd428361011;
    localparam logic [63:0] SAMPLE_FULL = 64'd32767;
    localparam logic [63:0] SPAN_Q12 = 64'd24576;
    localparam logic [63:0] EXP_WHOLE [5] = '{
        64'd1073741824, 64'd395007542, 64'd145315154, 64'd53458458, 64'd19666267
    };

    logic [CDF_W-1:0]  cdf_q16 [TABLE_ENTRIES];
    logic [OUT_W-1:0]  expected_normal [$];

    // Normal density at grid point -3 + 3*j/TABLE_ENTRIES, Q30.
    function automatic logic [63:0] gauss_pdf_q30(input logic [63:0] j);
        logic [63:0] len;
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] whole;
        logic [63:0] part;
        logic [63:0] term;
        longint      series;
        len = 64'(TABLE_ENTRIES);
        d = (j >= len) ? (j - len) : (len - j);
        t = ((64'd9 * d * d) << 29) / (len * len);
        whole = t >> 30;
        part = t & Q30_FRAC;
        if (whole > 64'd4)
        begin
            return 64'd0;
        end
        term = Q30_ONE;
        series = longint'(Q30_ONE);
        for (int k = 1; k <= 16; k++)
        begin
            term = ((term * part) >> 30) / 64'(k);
            if ((k % 2) == 1)
            begin
                series = series - longint'(term);
            end
            else
            begin
                series = series + longint'(term);
            end
        end
        if (series < 0)
        begin
            series = 0;
        end
        return (PDF_SCALE * ((64'(series) * EXP_WHOLE[whole]) >> 30)) >> 30;
    endfunction

    function automatic logic [OUT_W-1:0] inv_cdf_value(input logic [SMP_W-1:0] u);
        logic [63:0] scaled;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] div;
        int          idx;
        longint      r;
        if (u == '0)
        begin
            return '0;
        end
        scaled = 64'(u) << 16;
        idx = 0;
        while (idx < TABLE_ENTRIES && scaled > 64'(cdf_q16[idx]) * SAMPLE_FULL)
        begin
            idx++;
        end
        if (idx >= TABLE_ENTRIES || idx == 0)
        begin
            r = OUT_PLUS3;
        end
        else
        begin
            lo = 64'(cdf_q16[idx-1]) * SAMPLE_FULL;
            hi = 64'(cdf_q16[idx]) * SAMPLE_FULL;
            den = hi - lo;
            if (den == 64'd0)
            begin
                num = SPAN_Q12 * 64'(idx - 1);
                div = 64'(TABLE_ENTRIES);
            end
            else
            begin
                num = SPAN_Q12 * (64'(idx - 1) * den + (scaled - lo));
                div = 64'(TABLE_ENTRIES) * den;
            end
            r = longint'((num + div / 2) / div) - OUT_PLUS3;
            if (r > OUT_PLUS3)
            begin
                r = OUT_PLUS3;
            end
            if (r < OUT_MINUS3)
            begin
                r = OUT_MINUS3;
            end
        end
        return r[OUT_W-1:0];
    endfunction

    initial
    begin
        logic [63:0] len;
        logic [63:0] acc;
        logic [63:0] v;
        logic [63:0] ii;
        errors = 0;
        pending = 0;
        checked = 0;
        zero_cnt = 0;
        top_cnt = 0;
        len = 64'(TABLE_ENTRIES);
        acc = 64'd0;
        cdf_q16[0] = '0;
        for (int i = 1; i < TABLE_ENTRIES; i++)
        begin
            ii = 64'(i);
            acc = acc + gauss_pdf_q30(2 * ii - 2) + 64'd4 * gauss_pdf_q30(2 * ii - 1)
                + gauss_pdf_q30(2 * ii);
            v = (acc + len * 64'd8192) / (len * 64'd16384);
            if (v > 64'd65535)
            begin
                v = 64'd65535;
            end
            cdf_q16[i] = v[CDF_W-1:0];
        end
    end

    always @(posedge clk)
    begin : compare
        logic [OUT_W-1:0] want;
        logic [OUT_W-1:0] got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = inv_cdf_value(s_axis_tdata[SMP_W-1:0]);
                expected_normal.push_back(want);
                if (s_axis_tdata[SMP_W-1:0] == '0)
                begin
                    zero_cnt++;
                end
                else if ($signed(want) == OUT_PLUS3)
                begin
                    top_cnt++;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[OUT_W-1:0];
                if (expected_normal.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: unexpected result transfer, normal_value %0d",
                                 $realtime, $signed(got));
                    end
                end
                else
                begin
                    want = expected_normal.pop_front();
                    checked++;
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: normal_value mismatch on result %0d: expected %0d, got %0d",
                                     $realtime, checked, $signed(want), $signed(got));
                        end
                    end
                end
            end
            pending <= expected_normal.size();
        end
    end

endmodule

// File: tb/tb_gaussian_inverse_cdf_sampler.sv
`timescale 1ns / 100ps
// Top-level testbench of the gaussian inverse-CDF sampler: stimulus, watchdog and verdict.
module tb_gaussian_inverse_cdf_sampler;
    import gics_pkg::*;

    localparam int RANDOM_SAMPLES = 1850;
    localparam int CALM_TAIL = 200;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int CORNER_COUNT = 24;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [14:0] uniform_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [14:0] normal_value

    int errors;
    int pending;
    int checked;
    int zero_cnt;
    int top_cnt;
    int idle_cycles = 0;
    bit calm = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    gaussian_inverse_cdf_sampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    normal_sample_checker normal_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .zero_cnt      (zero_cnt),
        .top_cnt       (top_cnt)
    );

    // Hold the sample until the transfer, optionally after a gap.
    task automatic send_sample(input logic [SMP_W-1:0] u);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'(u);
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [SMP_W-1:0] corner [CORNER_COUNT];
        logic [SMP_W-1:0] u;
        int               pick;
        corner = '{
            15'd0, 15'd1, 15'd2, 15'd3, 15'd7, 15'd64, 15'd255, 15'd4096,
            15'd8191, 15'd16383, 15'd16384, 15'd16385, 15'd21845, 15'd10922, 15'd24576,
            15'd30000, 15'd32600, 15'd32675, 15'd32700, 15'd32766, 15'd32767, 15'd0,
            15'd32767, 15'd1
        };
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int k = 0; k < CORNER_COUNT; k++)
        begin
            send_sample(corner[k]);
        end
        for (int n = 0; n < RANDOM_SAMPLES; n++)
        begin
            if (n == RANDOM_SAMPLES - CALM_TAIL)
            begin
                calm <= 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                u = '0;
            end
            else if (pick <= 2)
            begin
                u = SMP_W'($urandom_range(1, 300));
            end
            else if (pick <= 4)
            begin
                u = SMP_W'($urandom_range(32500, 32767));
            end
            else
            begin
                u = SMP_W'($urandom_range(0, 32767));
            end
            send_sample(u);
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d normal values from %0d uniform samples", checked,
                 CORNER_COUNT + RANDOM_SAMPLES);
        $display("Zero samples: %0d, clamped to +3: %0d, interpolated: %0d, mismatches: %0d",
                 zero_cnt, top_cnt, checked - zero_cnt - top_cnt, errors);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin : result_stall
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                hold = $urandom_range(0, 8);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 30);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("No transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, pending);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// File: files.f
hw/rtl/gics_pkg.sv
hw/rtl/gics_cdf_rom.sv
hw/rtl/gics_divider.sv
hw/rtl/gaussian_inverse_cdf_sampler.sv
tb/normal_sample_checker.sv
tb/tb_gaussian_inverse_cdf_sampler.sv
